@@ rtl/lse_pkg.sv @@
// shared types, latencies and constant tables of the logarithmic strain energy evaluator
// depends on nothing; every other rtl file except lse_div takes names from here by scope
`default_nettype none

package lse_pkg;

    localparam int LN_STEPS   = 62;
    localparam int LOG_LAT    = LN_STEPS + 2;
    localparam int DIV1_N     = 97;
    localparam int DIV2_N     = 96;
    localparam int NUM_SHIFT  = 30;
    localparam int LANE_LAT   = LOG_LAT + 3 + (DIV1_N + 1) + (DIV2_N + 1) + 1;
    localparam int ENERGY_LAT = 7;
    localparam int ALIGN_LAT  = LANE_LAT - LOG_LAT - ENERGY_LAT;
    localparam int PIPE_LAT   = LANE_LAT + 1;
    localparam int ISO_SHIFT  = 47;
    localparam int VOL_SHIFT  = 48;

    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_BULK  = 1'd0;
    localparam cfg_idx_t REG_SHEAR = 1'd1;

    typedef struct packed {
        logic [31:0] stretch_a;
        logic [31:0] stretch_b;
        logic [31:0] stretch_c;
        logic [31:0] volume_ratio;
    } item_t;

    typedef struct packed {
        logic signed [47:0] energy;
        logic signed [47:0] slope_a;
        logic signed [47:0] slope_b;
        logic signed [47:0] slope_c;
        logic signed [47:0] curve_a;
        logic signed [47:0] curve_b;
        logic signed [47:0] curve_c;
        logic signed [47:0] vol_slope;
        logic signed [47:0] vol_curve;
        logic               bad_input;
    } result_t;

    typedef logic [63:0] step_tab_t [1:LN_STEPS];

    // shift-subtract division, only used to build constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + 2^-k) in q2.62 from its alternating series
    function automatic logic [63:0] ln_step_f(input int k);
        logic [63:0] sum;
        logic [63:0] term;
        sum = '0;
        for (int n = 1; n * k <= 62; n++)
        begin
            term = udiv64(64'd1 << (62 - n * k), 64'(n));
            if ((n & 1) != 0)
                sum = sum + term;
            else
                sum = sum - term;
        end
        return sum;
    endfunction

    function automatic step_tab_t make_step_tab();
        step_tab_t tab;
        for (int k = 1; k <= LN_STEPS; k++)
            tab[k] = ln_step_f(k);
        return tab;
    endfunction

    // greedy log of the mantissa 2.0
    function automatic logic [63:0] ln_two_f();
        logic [63:0] z;
        logic [63:0] acc;
        logic [63:0] t;
        z   = 64'h4000_0000_0000_0000;
        acc = '0;
        for (int k = 1; k <= LN_STEPS; k++)
        begin
            t = z + (z >> k);
            if (t <= 64'h8000_0000_0000_0000)
            begin
                z   = t;
                acc = acc + ln_step_f(k);
            end
        end
        return acc;
    endfunction

    localparam step_tab_t   LN_STEP = make_step_tab();
    localparam logic [63:0] LN2_Q56 = (ln_two_f() + 64'd32) >> 6;
    localparam logic [63:0] ONE_Q56 = 64'h0100_0000_0000_0000;

    // round a quotient to q24.24 half up, saturate, apply sign
    function automatic logic [47:0] sat_round(input logic [96:0] q, input logic ovf,
                                              input int sh, input logic neg);
        logic [97:0] sum;
        logic [97:0] r;
        logic [97:0] lim;
        logic [97:0] mag;
        sum = {1'b0, q} + (98'd1 << (sh - 1));
        r   = sum >> sh;
        lim = neg ? 98'h8000_0000_0000 : 98'h7FFF_FFFF_FFFF;
        mag = (ovf || (r > lim)) ? lim : r;
        return neg ? 48'(-mag) : 48'(mag);
    endfunction

endpackage

`default_nettype wire

@@ rtl/log_strain_energy_eval.sv @@
// top level of the logarithmic strain energy evaluator: modulus registers, four lanes,
// merging stage, valid line and output register; depends on lse_pkg, lse_lane, lse_merge
//
// usage
//   item channel: item_valid / item_stall with one item_t word (three stretches, volume ratio)
//   result channel: result_valid / result_stall with one result_t word per item
//   config channel: cfg_valid / cfg_ready (always ready), cfg_index, cfg_data;
//   index 0 writes the bulk modulus, index 1 the shear modulus; write only while idle
//   latency: 264 register stages; a result is offered from the output register once its item
//   has passed them all; the 62 stages of the shift-and-add log and the two chained
//   restoring dividers (98 and 97 stages) set it
//   throughput: one item per cycle while the output is not stalled; every lane stage holds one item
//   stall: while a result waits and result_stall is high the whole pipeline holds and
//   item_stall is raised; nothing is lost or repeated
//   a word with any zero field returns bad_input set and all numeric fields zero
//   reset clears the valid line and both moduli to zero
`default_nettype none

module log_strain_energy_eval (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  lse_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output lse_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int PL = lse_pkg::PIPE_LAT;

    logic [31:0]      bulk_reg, shear_reg;
    logic [PL-1:0]    vld_reg;
    logic             en;
    logic             bad_in;
    lse_pkg::result_t result_reg;
    lse_pkg::result_t result_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bulk_reg  <= '0;
            shear_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lse_pkg::REG_BULK:  bulk_reg  <= cfg_data;
                lse_pkg::REG_SHEAR: shear_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the output word is held
    assign en         = !(vld_reg[PL-1] && result_stall);
    assign item_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PL-2:0], item_valid};
    end

    assign bad_in = (item.stretch_a == 32'd0) || (item.stretch_b == 32'd0) ||
                    (item.stretch_c == 32'd0) || (item.volume_ratio == 32'd0);

    logic signed [63:0] log_a, log_b, log_c, log_v;
    logic signed [47:0] sl_a, sl_b, sl_c, sl_v;
    logic signed [47:0] cv_a, cv_b, cv_c, cv_v;
    logic signed [47:0] energy;
    logic               bad;

    lse_lane #(.RND_SHIFT(lse_pkg::ISO_SHIFT)) u_lane_a (
        .clk (clk), .en (en), .x (item.stretch_a), .modulus (shear_reg),
        .log_val (log_a), .slope (sl_a), .curve (cv_a)
    );

    lse_lane #(.RND_SHIFT(lse_pkg::ISO_SHIFT)) u_lane_b (
        .clk (clk), .en (en), .x (item.stretch_b), .modulus (shear_reg),
        .log_val (log_b), .slope (sl_b), .curve (cv_b)
    );

    lse_lane #(.RND_SHIFT(lse_pkg::ISO_SHIFT)) u_lane_c (
        .clk (clk), .en (en), .x (item.stretch_c), .modulus (shear_reg),
        .log_val (log_c), .slope (sl_c), .curve (cv_c)
    );

    lse_lane #(.RND_SHIFT(lse_pkg::VOL_SHIFT)) u_lane_v (
        .clk (clk), .en (en), .x (item.volume_ratio), .modulus (bulk_reg),
        .log_val (log_v), .slope (sl_v), .curve (cv_v)
    );

    lse_merge u_merge (
        .clk    (clk),
        .en     (en),
        .log_a  (log_a),
        .log_b  (log_b),
        .log_c  (log_c),
        .log_v  (log_v),
        .shear  (shear_reg),
        .bulk   (bulk_reg),
        .bad_in (bad_in),
        .energy (energy),
        .bad    (bad)
    );

    always_comb
    begin
        result_next.energy    = bad ? '0 : energy;
        result_next.slope_a   = bad ? '0 : sl_a;
        result_next.slope_b   = bad ? '0 : sl_b;
        result_next.slope_c   = bad ? '0 : sl_c;
        result_next.curve_a   = bad ? '0 : cv_a;
        result_next.curve_b   = bad ? '0 : cv_b;
        result_next.curve_c   = bad ? '0 : cv_c;
        result_next.vol_slope = bad ? '0 : sl_v;
        result_next.vol_curve = bad ? '0 : cv_v;
        result_next.bad_input = bad;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result_valid = vld_reg[PL-1];
    assign result       = result_reg;

endmodule

`default_nettype wire

@@ rtl/lse_div.sv @@
// pipelined restoring divider: one quotient bit per stage, 32-bit divisor
// depends on nothing outside itself
`default_nettype none

module lse_div #(
    parameter int N  = 97,
    parameter int DW = 126,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] dividend,
    input  logic [31:0]   divisor,
    input  logic          ovf_in,
    input  logic [SW-1:0] side_in,
    output logic [N-1:0]  quot,
    output logic          ovf,
    output logic [31:0]   divisor_out,
    output logic [SW-1:0] side_out
);

    logic [31:0]   rem_reg  [0:N];
    logic [N-1:0]  low_reg  [0:N];
    logic [31:0]   dvs_reg  [0:N];
    logic          ovf_reg  [0:N];
    logic [SW-1:0] side_reg [0:N];

    logic [32:0]   r2       [0:N-1];
    logic [N-1:0]  qb;
    logic [31:0]   rem_next [0:N-1];
    logic [N-1:0]  low_next [0:N-1];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            r2[i] = {rem_reg[i], low_reg[i][N-1]};
            qb[i] = r2[i] >= {1'b0, dvs_reg[i]};
            rem_next[i] = qb[i] ? 32'(r2[i] - {1'b0, dvs_reg[i]}) : r2[i][31:0];
            low_next[i] = {low_reg[i][N-2:0], qb[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient at or above 2^N saturates later
            rem_reg[0]  <= 32'(dividend >> N);
            low_reg[0]  <= dividend[N-1:0];
            dvs_reg[0]  <= divisor;
            ovf_reg[0]  <= ovf_in | ((dividend >> N) >= DW'(divisor));
            side_reg[0] <= side_in;
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i+1]  <= rem_next[i];
                low_reg[i+1]  <= low_next[i];
                dvs_reg[i+1]  <= dvs_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign quot        = low_reg[N];
    assign ovf         = ovf_reg[N];
    assign divisor_out = dvs_reg[N];
    assign side_out    = side_reg[N];

endmodule

`default_nettype wire

@@ rtl/lse_lane.sv @@
// one lane: log of a q2.30 value, then c*ln/x and c*(1-ln)/x^2 through dividers
// depends on lse_pkg and lse_div
`default_nettype none

module lse_lane #(
    parameter int RND_SHIFT = 47
) (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        x,
    input  logic [31:0]        modulus,
    output logic signed [63:0] log_val,
    output logic signed [47:0] slope,
    output logic signed [47:0] curve
);

    localparam int NS = lse_pkg::LN_STEPS;

    // log section
    logic [63:0] z_reg   [0:NS];
    logic [63:0] acc_reg [0:NS];
    logic [63:0] m_reg   [0:NS];
    logic [4:0]  p_reg   [0:NS];
    logic [31:0] x_reg   [0:NS];
    logic [63:0] z_next  [1:NS];
    logic [63:0] acc_next[1:NS];
    logic [4:0]  p_next;
    logic [63:0] m_next;

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < 32; i++)
            if (x[i])
                p_next = 5'(i);
        m_next = {32'b0, x} << (6'd62 - {1'b0, p_next});
    end

    always_comb
    begin
        for (int k = 1; k <= NS; k++)
        begin
            z_next[k] = z_reg[k-1] + (z_reg[k-1] >> k);
            if (z_next[k] <= m_reg[k-1])
                acc_next[k] = acc_reg[k-1] + lse_pkg::LN_STEP[k];
            else
            begin
                z_next[k]   = z_reg[k-1];
                acc_next[k] = acc_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]   <= 64'h4000_0000_0000_0000;
            acc_reg[0] <= '0;
            m_reg[0]   <= m_next;
            p_reg[0]   <= p_next;
            x_reg[0]   <= x;
            for (int k = 1; k <= NS; k++)
            begin
                z_reg[k]   <= z_next[k];
                acc_reg[k] <= acc_next[k];
                m_reg[k]   <= m_reg[k-1];
                p_reg[k]   <= p_reg[k-1];
                x_reg[k]   <= x_reg[k-1];
            end
        end
    end

    // exponent times ln2 plus rounded mantissa log
    logic signed [6:0]  pm30;
    logic signed [63:0] lterm;
    logic [63:0]        frac;
    logic signed [63:0] l_reg;
    logic [31:0]        xl_reg;

    always_comb
    begin
        pm30  = $signed({2'b0, p_reg[NS]}) - 7'sd30;
        lterm = 64'(pm30) * $signed(lse_pkg::LN2_Q56);
        frac  = (acc_reg[NS] + 64'd32) >> 6;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg  <= lterm + $signed(frac);
            xl_reg <= x_reg[NS];
        end
    end

    assign log_val = l_reg;

    // magnitudes, products with the modulus
    logic signed [63:0] d_next;
    logic [63:0] magl_reg, magd_reg;
    logic        negl_reg, negd_reg;
    logic [31:0] xm_reg;
    logic [63:0] plh_reg, pll_reg, pdh_reg, pdl_reg;
    logic        negl2_reg, negd2_reg;
    logic [31:0] xp_reg;
    logic [95:0] numl_reg, numd_reg;
    logic        negl3_reg, negd3_reg;
    logic [31:0] xc_reg;

    assign d_next = $signed(lse_pkg::ONE_Q56) - l_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            magl_reg  <= l_reg[63] ? 64'(-l_reg) : l_reg;
            negl_reg  <= l_reg[63];
            magd_reg  <= d_next[63] ? 64'(-d_next) : d_next;
            negd_reg  <= d_next[63];
            xm_reg    <= xl_reg;

            plh_reg   <= 64'(magl_reg[63:32]) * 64'(modulus);
            pll_reg   <= 64'(magl_reg[31:0]) * 64'(modulus);
            pdh_reg   <= 64'(magd_reg[63:32]) * 64'(modulus);
            pdl_reg   <= 64'(magd_reg[31:0]) * 64'(modulus);
            negl2_reg <= negl_reg;
            negd2_reg <= negd_reg;
            xp_reg    <= xm_reg;

            numl_reg  <= {plh_reg, 32'b0} + 96'(pll_reg);
            numd_reg  <= {pdh_reg, 32'b0} + 96'(pdl_reg);
            negl3_reg <= negl2_reg;
            negd3_reg <= negd2_reg;
            xc_reg    <= xp_reg;
        end
    end

    // first division for both slope and curve
    localparam int DW1 = 96 + lse_pkg::NUM_SHIFT;
    localparam int N1  = lse_pkg::DIV1_N;
    localparam int N2  = lse_pkg::DIV2_N;
    localparam int DW2 = N1 + lse_pkg::NUM_SHIFT;
    localparam int SW2 = N1 + 3;

    logic [N1-1:0] qs, q1;
    logic          ovfs, ovf1;
    logic          negl_o, negd_o;
    logic [31:0]   x1;
    logic [31:0]   xs_unused;

    lse_div #(.N(N1), .DW(DW1), .SW(1)) u_div_slope (
        .clk         (clk),
        .en          (en),
        .dividend    ({numl_reg, 30'b0}),
        .divisor     (xc_reg),
        .ovf_in      (1'b0),
        .side_in     (negl3_reg),
        .quot        (qs),
        .ovf         (ovfs),
        .divisor_out (xs_unused),
        .side_out    (negl_o)
    );

    lse_div #(.N(N1), .DW(DW1), .SW(1)) u_div_curve1 (
        .clk         (clk),
        .en          (en),
        .dividend    ({numd_reg, 30'b0}),
        .divisor     (xc_reg),
        .ovf_in      (1'b0),
        .side_in     (negd3_reg),
        .quot        (q1),
        .ovf         (ovf1),
        .divisor_out (x1),
        .side_out    (negd_o)
    );

    // second division by x for the curve; slope word rides along
    logic [N2-1:0]  q2;
    logic           ovf2;
    logic [SW2-1:0] side2;
    logic [31:0]    x2_unused;

    lse_div #(.N(N2), .DW(DW2), .SW(SW2)) u_div_curve2 (
        .clk         (clk),
        .en          (en),
        .dividend    ({q1, 30'b0}),
        .divisor     (x1),
        .ovf_in      (ovf1),
        .side_in     ({qs, ovfs, negl_o, negd_o}),
        .quot        (q2),
        .ovf         (ovf2),
        .divisor_out (x2_unused),
        .side_out    (side2)
    );

    logic [47:0] slope_reg, curve_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slope_reg <= lse_pkg::sat_round(side2[SW2-1:3], side2[2], RND_SHIFT, side2[1]);
            curve_reg <= lse_pkg::sat_round({1'b0, q2}, ovf2, RND_SHIFT, side2[0]);
        end
    end

    assign slope = $signed(slope_reg);
    assign curve = $signed(curve_reg);

endmodule

`default_nettype wire

@@ rtl/lse_merge.sv @@
// merging stage: energy from the four lane logs, aligned with the lane results
// depends on lse_pkg
`default_nettype none

module lse_merge (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] log_a,
    input  logic signed [63:0] log_b,
    input  logic signed [63:0] log_c,
    input  logic signed [63:0] log_v,
    input  logic [31:0]        shear,
    input  logic [31:0]        bulk,
    input  logic               bad_in,
    output logic signed [47:0] energy,
    output logic               bad
);

    localparam int AL = lse_pkg::ALIGN_LAT;
    localparam int LL = lse_pkg::LANE_LAT;

    logic signed [63:0] lg [0:3];
    logic [63:0] mag_reg [0:3];
    logic [63:0] hh_reg  [0:3];
    logic [63:0] hl_reg  [0:3];
    logic [63:0] ll_reg  [0:3];
    logic [95:0] sq_reg  [0:3];
    logic [95:0] sum_reg, sqv_reg;
    logic [63:0] g_reg   [0:2];
    logic [63:0] k_reg   [0:2];
    logic [127:0] tot_reg;
    logic [127:0] gsum, ksum, rsum;
    logic [127:0] sq_full [0:3];
    logic [47:0] e_reg;
    logic [47:0] e_next;
    logic [47:0] dly_reg [0:AL-1];
    logic [LL-1:0] bad_reg;

    assign lg[0] = log_a;
    assign lg[1] = log_b;
    assign lg[2] = log_c;
    assign lg[3] = log_v;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            sq_full[i] = ({hh_reg[i], 64'b0} + (128'(hl_reg[i]) << 33) + 128'(ll_reg[i])) >> 32;
        gsum = 128'(g_reg[0]) + (128'(g_reg[1]) << 32) + (128'(g_reg[2]) << 64);
        ksum = 128'(k_reg[0]) + (128'(k_reg[1]) << 32) + (128'(k_reg[2]) << 64);
        rsum = (tot_reg + (128'd1 << 72)) >> 73;
        e_next = (rsum > 128'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : rsum[47:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag_reg[i] <= lg[i][63] ? 64'(-lg[i]) : lg[i];
                hh_reg[i]  <= 64'(mag_reg[i][63:32]) * 64'(mag_reg[i][63:32]);
                hl_reg[i]  <= 64'(mag_reg[i][63:32]) * 64'(mag_reg[i][31:0]);
                ll_reg[i]  <= 64'(mag_reg[i][31:0]) * 64'(mag_reg[i][31:0]);
                sq_reg[i]  <= sq_full[i][95:0];
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sqv_reg <= sq_reg[3];
            for (int j = 0; j < 3; j++)
            begin
                g_reg[j] <= 64'(sum_reg[32*j +: 32]) * 64'(shear);
                k_reg[j] <= 64'(sqv_reg[32*j +: 32]) * 64'(bulk);
            end
            tot_reg <= (gsum << 1) + ksum;
            e_reg   <= e_next;

            // hold the energy until the lanes catch up
            dly_reg[0] <= e_reg;
            for (int i = 1; i < AL; i++)
                dly_reg[i] <= dly_reg[i-1];

            bad_reg <= {bad_reg[LL-2:0], bad_in};
        end
    end

    assign energy = $signed(dly_reg[AL-1]);
    assign bad    = bad_reg[LL-1];

endmodule

`default_nettype wire
